// ----- sv/hhs_pkg.sv -----
// Shared types, constants and the hash step program for the heavy-hitter sketch update.
package hhs_pkg;

    // Store geometry
    localparam int ROW_BUCKETS  = 1024;
    localparam int ROW_BITS     = $clog2(ROW_BUCKETS);
    localparam int ROWS         = 4;
    localparam int ROW_IDX_BITS = $clog2(ROWS);
    localparam int DEPTH        = ROWS * ROW_BUCKETS;
    localparam int ADDR_BITS    = $clog2(DEPTH);
    localparam int KEY_BITS     = 64;
    localparam int WIDTH_BITS   = 11;
    localparam int ENTRY_BITS   = KEY_BITS + 64;

    // Hash constants
    localparam logic [63:0] HASH_C1  = 64'h87c37b91114253d5;
    localparam logic [63:0] HASH_C2  = 64'h4cf5ad432745937f;
    localparam logic [63:0] FMIX_C1  = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2  = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] KEY_LEN  = 64'(KEY_BITS / 8);

    // Register indexes and reset values
    localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
    localparam logic [1:0] REG_HASH_SEED = 2'd1;
    localparam logic [1:0] REG_LOW_LIMIT = 2'd2;
    localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = 11'd1024;
    localparam logic [15:0] LOW_LIMIT_RESET = 16'd10;

    // Action codes
    localparam logic [2:0] ACT_MATCH    = 3'd0;
    localparam logic [2:0] ACT_INSERT   = 3'd1;
    localparam logic [2:0] ACT_DECAY    = 3'd2;
    localparam logic [2:0] ACT_REPLACE  = 3'd3;
    localparam logic [2:0] ACT_NO_DECAY = 3'd4;

    localparam int HASH_STEPS = 20;
    localparam logic [4:0] HASH_LAST = 5'(HASH_STEPS - 1);

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_MUL, OP_ROT, OP_XH, OP_ADD12, OP_ADD21,
        OP_KH1, OP_KH2, OP_XS, OP_H1K, OP_H2K, OP_BKT, OP_RD, OP_CHK,
        OP_DEC, OP_PROD, OP_DSET, OP_DIV, OP_DECIDE, OP_WR
    } dp_op_t;

    typedef enum logic [1:0] {SEL_C1, SEL_C2, SEL_F1, SEL_F2} mul_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_HWAIT, ST_BKT, ST_RD, ST_CHK,
        ST_DEC, ST_PROD, ST_DSET, ST_DIV, ST_DECIDE, ST_WR
    } ctl_state_t;

    typedef struct packed {
        dp_op_t                  op;
        mul_sel_t                sel;
        logic [ROW_IDX_BITS-1:0] vidx;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic hit;
        logic skip_div;
        logic div_last;
        logic clear_last;
    } dp_status_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t sel;
    } hash_step_t;

    // Hash program: seeded 128-bit hash of one 8-byte key
    function automatic hash_step_t hash_prog(input logic [4:0] step);
        hash_step_t s;
        s.sel = SEL_C1;
        unique case (step)
            5'd0:    s.op = OP_MUL;
            5'd1:    s.op = OP_ROT;
            5'd2:    begin s.op = OP_MUL; s.sel = SEL_C2; end
            5'd3:    s.op = OP_XH;
            5'd4:    s.op = OP_ADD12;
            5'd5:    s.op = OP_ADD21;
            5'd6:    s.op = OP_KH1;
            5'd7:    begin s.op = OP_MUL; s.sel = SEL_F1; end
            5'd8:    s.op = OP_XS;
            5'd9:    begin s.op = OP_MUL; s.sel = SEL_F2; end
            5'd10:   s.op = OP_XS;
            5'd11:   s.op = OP_H1K;
            5'd12:   s.op = OP_KH2;
            5'd13:   begin s.op = OP_MUL; s.sel = SEL_F1; end
            5'd14:   s.op = OP_XS;
            5'd15:   begin s.op = OP_MUL; s.sel = SEL_F2; end
            5'd16:   s.op = OP_XS;
            5'd17:   s.op = OP_H2K;
            5'd18:   s.op = OP_ADD12;
            5'd19:   s.op = OP_ADD21;
            default: s.op = OP_NONE;
        endcase
        return s;
    endfunction

endpackage

// ----- sv/hhs_mul64.sv -----
// Iterative 64 by 64 multiplier keeping the low 64 product bits, one 32x32 product a cycle.
module hhs_mul64
    import hhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    logic [1:0]  ph_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] full_reg;
    logic [31:0] cross_reg;
    logic [63:0] res_reg;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod;

    // Pick the partial product for this phase
    always_comb
    begin
        unique case (ph_reg)
            2'd1:
            begin
                mx = a_reg[31:0];
                my = b_reg[63:32];
            end
            2'd2:
            begin
                mx = a_reg[63:32];
                my = b_reg[31:0];
            end
            default:
            begin
                mx = a_reg[31:0];
                my = b_reg[31:0];
            end
        endcase
        prod = mx * my;
    end

    // Sequence the phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= 2'd0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            ph_reg   <= 2'd0;
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            ph_reg   <= ph_reg + 2'd1;
            run_reg  <= (ph_reg != 2'd3);
            done_reg <= (ph_reg == 2'd3);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Accumulate partial products
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (run_reg)
        begin
            unique case (ph_reg)
                2'd0: full_reg  <= prod;
                2'd1: cross_reg <= prod[31:0];
                2'd2: cross_reg <= cross_reg + prod[31:0];
                2'd3: res_reg   <= full_reg + {cross_reg, 32'd0};
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- sv/hhs_datapath.sv -----
// Datapath: configuration, hash registers, bucket store, decay test and result registers.
module hhs_datapath
    import hhs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic [KEY_BITS-1:0]     flow_key,
    input  logic [30:0]             random_value,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    output logic                    done,
    output logic [2:0]              action,
    output logic [ROW_IDX_BITS-1:0] row_hit,
    output logic [ROW_BITS-1:0]     bucket_hit,
    output logic [31:0]             count_after,
    output logic signed [31:0]      hot_after
);

    // Configuration
    logic [WIDTH_BITS-1:0] row_width_reg;
    logic [31:0]           hash_seed_reg;
    logic [15:0]           low_limit_reg;

    // Item and hash state
    logic [KEY_BITS-1:0]   key_reg;
    logic [30:0]           rnd_reg;
    logic [63:0]           k_reg;
    logic [63:0]           h1_reg;
    logic [63:0]           h2_reg;
    logic [WIDTH_BITS-1:0] w_reg;
    logic [ROW_BITS-1:0]   slot_reg [ROWS];

    // Store and update state
    logic [ENTRY_BITS-1:0] mem [DEPTH];
    logic [ENTRY_BITS-1:0] rd_reg;
    logic [ADDR_BITS-1:0]  clr_reg;
    logic [31:0]           min_cnt_reg;
    logic [31:0]           min_hot_reg;
    logic [KEY_BITS-1:0]   min_key_reg;
    logic [ROW_IDX_BITS-1:0] min_vidx_reg;
    logic [ROW_IDX_BITS-1:0] loc_reg;
    logic [KEY_BITS-1:0]   wr_key_reg;
    logic [31:0]           wr_cnt_reg;
    logic [31:0]           wr_hot_reg;
    logic [2:0]            act_reg;
    logic [31:0]           hot_d_reg;
    logic                  low_reg;
    logic signed [64:0]    p_reg;
    logic [63:0]           d_reg;
    logic                  forced_reg;
    logic                  big_reg;
    logic [31:0]           rem_reg;
    logic [4:0]            bit_reg;
    logic                  done_reg;
    logic [2:0]            action_reg;
    logic [ROW_IDX_BITS-1:0] row_hit_reg;
    logic [ROW_BITS-1:0]   bucket_hit_reg;
    logic [31:0]           count_after_reg;
    logic [31:0]           hot_after_reg;

    // Combinational helpers
    logic [WIDTH_BITS-1:0] w_eff;
    logic [63:0]           mul_b;
    logic                  mul_done;
    logic [63:0]           mul_res;
    logic [ROW_IDX_BITS-1:0] bkt_row;
    logic [31:0]           word;
    logic [WIDTH_BITS+31:0] bprod;
    logic [KEY_BITS-1:0]   rd_key;
    logic [31:0]           rd_cnt;
    logic [31:0]           rd_hot;
    logic                  match;
    logic                  empty;
    logic signed [32:0]    p_a;
    logic signed [32:0]    p_b;
    logic signed [64:0]    p_prod;
    logic [63:0]           dset_d;
    logic                  dset_forced;
    logic                  dset_big;
    logic [31:0]           rem_sh;
    logic [63:0]           rem_final;
    logic                  decay;
    logic [31:0]           cnt_dec;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_wa;
    logic [ENTRY_BITS-1:0] mem_wd;

    // Clamp the row width
    always_comb
    begin
        if (row_width_reg == '0)
            w_eff = WIDTH_BITS'(1);
        else if (row_width_reg > WIDTH_BITS'(ROW_BUCKETS))
            w_eff = WIDTH_BITS'(ROW_BUCKETS);
        else
            w_eff = row_width_reg;
    end

    // Select the multiplier constant
    always_comb
    begin
        unique case (cmd.sel)
            SEL_C1: mul_b = HASH_C1;
            SEL_C2: mul_b = HASH_C2;
            SEL_F1: mul_b = FMIX_C1;
            SEL_F2: mul_b = FMIX_C2;
        endcase
    end

    hhs_mul64 u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.op == OP_MUL),
        .a      (k_reg),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    // Scale the digest word of the visited row into a bucket
    assign bkt_row = ROW_IDX_BITS'(ROWS - 1) - cmd.vidx;
    always_comb
    begin
        unique case (bkt_row)
            2'd0: word = h1_reg[31:0];
            2'd1: word = h1_reg[63:32];
            2'd2: word = h2_reg[31:0];
            2'd3: word = h2_reg[63:32];
        endcase
        bprod = word * w_reg;
    end

    // Check the bucket just read
    assign rd_key = rd_reg[ENTRY_BITS-1:64];
    assign rd_cnt = rd_reg[63:32];
    assign rd_hot = rd_reg[31:0];
    assign match  = (rd_key == key_reg);
    assign empty  = (rd_cnt == 32'd0);

    // Count times hot count, exact signed product
    assign p_a    = $signed({1'b0, min_cnt_reg});
    assign p_b    = $signed({hot_d_reg[31], hot_d_reg});
    assign p_prod = p_a * p_b;

    // Pick the divisor for the decay test
    always_comb
    begin
        if (low_reg)
        begin
            dset_d      = 64'(min_cnt_reg) + 64'd1;
            dset_forced = 1'b0;
        end
        else
        begin
            dset_d      = p_reg[63:0] + 64'd1;
            dset_forced = p_reg[64] || (p_reg == '0);
        end
        dset_big = (dset_d > 64'(rnd_reg));
    end

    // One restoring remainder step and the final decision
    assign rem_sh    = {rem_reg[30:0], rnd_reg[bit_reg]};
    assign rem_final = big_reg ? 64'(rnd_reg) : 64'(rem_reg);
    assign decay     = forced_reg || (rem_final == (d_reg - 64'd1));
    assign cnt_dec   = min_cnt_reg - 32'd1;

    // Store write port
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = '0;
        if (cmd.op == OP_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.op == OP_WR)
        begin
            mem_we = 1'b1;
            mem_wa = {ROW_IDX_BITS'(ROWS - 1) - loc_reg, slot_reg[loc_reg]};
            mem_wd = {wr_key_reg, wr_cnt_reg, wr_hot_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (cmd.op == OP_RD)
            rd_reg <= mem[{ROW_IDX_BITS'(ROWS - 1) - cmd.vidx, slot_reg[cmd.vidx]}];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            hash_seed_reg <= '0;
            low_limit_reg <= LOW_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROW_WIDTH: row_width_reg <= cfg_data[WIDTH_BITS-1:0];
                REG_HASH_SEED: hash_seed_reg <= cfg_data;
                REG_LOW_LIMIT: low_limit_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Control registers: clear address and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
                clr_reg <= clr_reg + ADDR_BITS'(1);
            done_reg <= (cmd.op == OP_WR);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (mul_done)
            k_reg <= mul_res;
        unique case (cmd.op)
            OP_LOAD:
            begin
                key_reg <= flow_key;
                rnd_reg <= random_value;
                k_reg   <= flow_key;
                h1_reg  <= 64'(hash_seed_reg);
                h2_reg  <= 64'(hash_seed_reg);
                w_reg   <= w_eff;
            end
            OP_ROT:   k_reg  <= {k_reg[32:0], k_reg[63:33]};
            OP_XH:
            begin
                h1_reg <= h1_reg ^ k_reg ^ KEY_LEN;
                h2_reg <= h2_reg ^ KEY_LEN;
            end
            OP_ADD12: h1_reg <= h1_reg + h2_reg;
            OP_ADD21: h2_reg <= h2_reg + h1_reg;
            OP_KH1:   k_reg  <= h1_reg ^ (h1_reg >> 33);
            OP_KH2:   k_reg  <= h2_reg ^ (h2_reg >> 33);
            OP_XS:    k_reg  <= k_reg ^ (k_reg >> 33);
            OP_H1K:   h1_reg <= k_reg;
            OP_H2K:   h2_reg <= k_reg;
            OP_BKT:   slot_reg[cmd.vidx] <= bprod[ROW_BITS+31:32];
            OP_CHK:
            begin
                // Track the first minimum-count bucket
                if ((cmd.vidx == '0) || (rd_cnt < min_cnt_reg))
                begin
                    min_cnt_reg  <= rd_cnt;
                    min_hot_reg  <= rd_hot;
                    min_key_reg  <= rd_key;
                    min_vidx_reg <= cmd.vidx;
                end
                loc_reg <= cmd.vidx;
                if (match)
                begin
                    wr_key_reg <= rd_key;
                    wr_cnt_reg <= (rd_cnt == 32'hFFFFFFFF) ? rd_cnt : rd_cnt + 32'd1;
                    wr_hot_reg <= (rd_hot == 32'h7FFFFFFF) ? rd_hot : rd_hot + 32'd1;
                    act_reg    <= ACT_MATCH;
                end
                else
                begin
                    wr_key_reg <= key_reg;
                    wr_cnt_reg <= 32'd1;
                    wr_hot_reg <= 32'd1;
                    act_reg    <= ACT_INSERT;
                end
            end
            OP_DEC:
            begin
                loc_reg   <= min_vidx_reg;
                hot_d_reg <= (min_hot_reg == 32'h80000000) ? min_hot_reg
                                                           : min_hot_reg - 32'd1;
                low_reg   <= (min_cnt_reg < 32'(low_limit_reg));
            end
            OP_PROD:  p_reg <= p_prod;
            OP_DSET:
            begin
                d_reg      <= dset_d;
                forced_reg <= dset_forced;
                big_reg    <= dset_big;
                rem_reg    <= '0;
                bit_reg    <= 5'd30;
            end
            OP_DIV:
            begin
                rem_reg <= (rem_sh >= d_reg[31:0]) ? rem_sh - d_reg[31:0] : rem_sh;
                bit_reg <= bit_reg - 5'd1;
            end
            OP_DECIDE:
            begin
                wr_hot_reg <= hot_d_reg;
                if (decay && (cnt_dec == 32'd0))
                begin
                    wr_key_reg <= key_reg;
                    wr_cnt_reg <= 32'd1;
                    act_reg    <= ACT_REPLACE;
                end
                else if (decay)
                begin
                    wr_key_reg <= min_key_reg;
                    wr_cnt_reg <= cnt_dec;
                    act_reg    <= ACT_DECAY;
                end
                else
                begin
                    wr_key_reg <= min_key_reg;
                    wr_cnt_reg <= min_cnt_reg;
                    act_reg    <= ACT_NO_DECAY;
                end
            end
            OP_WR:
            begin
                action_reg      <= act_reg;
                row_hit_reg     <= ROW_IDX_BITS'(ROWS - 1) - loc_reg;
                bucket_hit_reg  <= slot_reg[loc_reg];
                count_after_reg <= wr_cnt_reg;
                hot_after_reg   <= wr_hot_reg;
            end
            default: ;
        endcase
    end

    // Status back to the controller
    always_comb
    begin
        status.mul_done   = mul_done;
        status.hit        = (cmd.op == OP_CHK) && (match || empty);
        status.skip_div   = dset_forced || dset_big;
        status.div_last   = (bit_reg == 5'd0);
        status.clear_last = (clr_reg == ADDR_BITS'(DEPTH - 1));
    end

    assign done        = done_reg;
    assign action      = action_reg;
    assign row_hit     = row_hit_reg;
    assign bucket_hit  = bucket_hit_reg;
    assign count_after = count_after_reg;
    assign hot_after   = $signed(hot_after_reg);

endmodule

// ----- sv/hhs_controller.sv -----
// Controller: sequences clearing, hashing, bucket visits, decay test and write-back.
module hhs_controller
    import hhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctl_state_t              state_reg;
    ctl_state_t              state_next;
    logic [4:0]              step_reg;
    logic [4:0]              step_next;
    logic [ROW_IDX_BITS-1:0] vidx_reg;
    logic [ROW_IDX_BITS-1:0] vidx_next;
    hash_step_t              hstep;

    assign hstep = hash_prog(step_reg);

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            vidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            vidx_reg  <= vidx_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        vidx_next  = vidx_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = SEL_C1;
        cmd.vidx   = vidx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    step_next  = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.op  = hstep.op;
                cmd.sel = hstep.sel;
                if (hstep.op == OP_MUL)
                begin
                    state_next = ST_HWAIT;
                end
                else if (step_reg == HASH_LAST)
                begin
                    vidx_next  = '0;
                    state_next = ST_BKT;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_HWAIT:
            begin
                if (status.mul_done)
                begin
                    step_next  = step_reg + 5'd1;
                    state_next = ST_HASH;
                end
            end
            ST_BKT:
            begin
                cmd.op    = OP_BKT;
                vidx_next = vidx_reg + ROW_IDX_BITS'(1);
                if (vidx_reg == ROW_IDX_BITS'(ROWS - 1))
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                cmd.op     = OP_RD;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                cmd.op = OP_CHK;
                if (status.hit)
                begin
                    state_next = ST_WR;
                end
                else if (vidx_reg == ROW_IDX_BITS'(ROWS - 1))
                begin
                    state_next = ST_DEC;
                end
                else
                begin
                    vidx_next  = vidx_reg + ROW_IDX_BITS'(1);
                    state_next = ST_RD;
                end
            end
            ST_DEC:
            begin
                cmd.op     = OP_DEC;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.op     = OP_PROD;
                state_next = ST_DSET;
            end
            ST_DSET:
            begin
                cmd.op     = OP_DSET;
                state_next = status.skip_div ? ST_DECIDE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (status.div_last)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.op     = OP_DECIDE;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.op     = OP_WR;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // Multiplier completes only while the hash waits on it
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> (state_reg == ST_HWAIT))
        else $error("multiplier done outside hash wait");

    // Write-back always returns to idle
    a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |=> (state_reg == ST_IDLE))
        else $error("write-back not followed by idle");

    // Clearing leaves only toward idle
    a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("clearing pass interrupted");

    // A hit ends the bucket scan at once
    a_hit_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK && status.hit) |=> (state_reg == ST_WR))
        else $error("hit did not lead to write-back");

endmodule

// ----- sv/heavy_hitter_sketch_update_top.sv -----
// Heavy-hitter sketch update: controller, datapath and bucket store.
// Done comes soonest on a match or insert in the first row visited; each further row adds
// a read and a check, and a decay test adds its own states and, unless skipped, 31 remainder
// steps. All six 64-bit hash products share the one 32x32 multiplier.
// Items are taken one at a time; start is taken again once busy falls.
// Reset: registers take their reset values and a clearing pass zeroes the store while busy
// is high; results cannot be stalled by the receiver.
module heavy_hitter_sketch_update_top
    import hhs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [KEY_BITS-1:0]     flow_key,
    input  logic [30:0]             random_value,
    output logic                    done,
    output logic [2:0]              action,
    output logic [ROW_IDX_BITS-1:0] row_hit,
    output logic [ROW_BITS-1:0]     bucket_hit,
    output logic [31:0]             count_after,
    output logic signed [31:0]      hot_after,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    hhs_controller u_ctl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    hhs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .flow_key     (flow_key),
        .random_value (random_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .action       (action),
        .row_hit      (row_hit),
        .bucket_hit   (bucket_hit),
        .count_after  (count_after),
        .hot_after    (hot_after)
    );

endmodule

// ----- test/heavy_hitter_sketch_update_top_tb.sv -----
// Self-checking testbench for the heavy-hitter sketch update block.
`timescale 1ns / 100ps

module heavy_hitter_sketch_update_top_tb
    import hhs_pkg::*;
();

    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         DRAIN_WAIT  = 120;

    typedef struct {
        logic [2:0]         action;
        logic [1:0]         row;
        logic [9:0]         bucket;
        logic [31:0]        count;
        logic signed [31:0] hot;
    } update_t;

    // Sketch predictor and store of predicted updates
    class sketch_scoreboard;
        logic [63:0]        keys  [DEPTH];
        logic [31:0]        counts[DEPTH];
        logic signed [31:0] hots  [DEPTH];
        logic [10:0]        width_reg;
        logic [31:0]        seed_reg;
        logic [15:0]        limit_reg;
        update_t            pending_updates[$];
        int                 errors;

        function void clear_store();
            for (int i = 0; i < DEPTH; i++)
            begin
                keys[i]   = '0;
                counts[i] = '0;
                hots[i]   = '0;
            end
            width_reg = ROW_WIDTH_RESET;
            seed_reg  = '0;
            limit_reg = LOW_LIMIT_RESET;
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_ROW_WIDTH)
                width_reg = data[10:0];
            else if (idx == REG_HASH_SEED)
                seed_reg = data;
            else if (idx == REG_LOW_LIMIT)
                limit_reg = data[15:0];
        endfunction

        function logic [63:0] final_mix(logic [63:0] k);
            k = k ^ (k >> 33);
            k = k * FMIX_C1;
            k = k ^ (k >> 33);
            k = k * FMIX_C2;
            k = k ^ (k >> 33);
            return k;
        endfunction

        // Hash the key, walk rows 3..0, fall back to the decay of the minimum bucket
        function void note_item(logic [63:0] key, logic [30:0] rnd);
            logic [63:0]  h1, h2, k1, w, b, cnt, up;
            logic [31:0]  words[4];
            int           slot[4];
            int           loc, s;
            logic [2:0]   act;
            logic         decay;
            longint       prod;
            update_t      u;
            h1 = {32'd0, seed_reg};
            h2 = {32'd0, seed_reg};
            k1 = key * HASH_C1;
            k1 = (k1 << 31) | (k1 >> 33);
            k1 = k1 * HASH_C2;
            h1 = h1 ^ k1 ^ KEY_LEN;
            h2 = h2 ^ KEY_LEN;
            h1 = h1 + h2;
            h2 = h2 + h1;
            h1 = final_mix(h1);
            h2 = final_mix(h2);
            h1 = h1 + h2;
            h2 = h2 + h1;
            words[0] = h1[31:0];
            words[1] = h1[63:32];
            words[2] = h2[31:0];
            words[3] = h2[63:32];
            w = width_reg;
            if (w == 0)
                w = 1;
            if (w > ROW_BUCKETS)
                w = ROW_BUCKETS;
            for (int i = 0; i < 4; i++)
            begin
                b = ({32'd0, words[3 - i]} * w) >> 32;
                slot[i] = (3 - i) * ROW_BUCKETS + int'(b);
            end
            act = ACT_NO_DECAY;
            loc = 0;
            for (int i = 0; i < 4; i++)
            begin
                s = slot[i];
                if (keys[s] == key)
                begin
                    if (counts[s] != 32'hFFFF_FFFF)
                        counts[s]++;
                    if (hots[s] != 32'sh7FFF_FFFF)
                        hots[s]++;
                    loc = i;
                    act = ACT_MATCH;
                    break;
                end
                if (counts[s] == 0)
                begin
                    keys[s]   = key;
                    counts[s] = 1;
                    hots[s]   = 1;
                    loc = i;
                    act = ACT_INSERT;
                    break;
                end
            end
            if (act == ACT_NO_DECAY)
            begin
                for (int i = 1; i < 4; i++)
                    if (counts[slot[i]] < counts[slot[loc]])
                        loc = i;
                s = slot[loc];
                if (hots[s] != 32'sh8000_0000)
                    hots[s]--;
                cnt = {32'd0, counts[s]};
                if (cnt < {48'd0, limit_reg})
                    decay = ({33'd0, rnd} % (cnt + 1)) == cnt;
                else
                begin
                    prod = longint'(cnt) * longint'(hots[s]);
                    up = prod;
                    decay = (prod <= 0) || (({33'd0, rnd} % (up + 1)) == up);
                end
                if (decay)
                begin
                    counts[s]--;
                    act = ACT_DECAY;
                    if (counts[s] == 0)
                    begin
                        keys[s]   = key;
                        counts[s] = 1;
                        act = ACT_REPLACE;
                    end
                end
            end
            s = slot[loc];
            u.action = act;
            u.row    = 2'(3 - loc);
            u.bucket = 10'(s % ROW_BUCKETS);
            u.count  = counts[s];
            u.hot    = hots[s];
            pending_updates = {pending_updates, u};
        endfunction

        function void check_update(update_t got);
            update_t want;
            if (pending_updates.size() == 0)
            begin
                $display("%0t: update with none predicted: action %0d", $time, got.action);
                errors++;
                return;
            end
            want = pending_updates.pop_front();
            if (got.action !== want.action)
            begin
                $display("%0t: action exp %0d act %0d", $time, want.action, got.action);
                errors++;
            end
            if (got.row !== want.row)
            begin
                $display("%0t: row_hit exp %0d act %0d", $time, want.row, got.row);
                errors++;
            end
            if (got.bucket !== want.bucket)
            begin
                $display("%0t: bucket_hit exp %0d act %0d", $time, want.bucket, got.bucket);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $display("%0t: count_after exp %0d act %0d", $time, want.count, got.count);
                errors++;
            end
            if (got.hot !== want.hot)
            begin
                $display("%0t: hot_after exp %0d act %0d", $time, want.hot, got.hot);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [63:0]        flow_key;
    logic [30:0]        random_value;
    logic               done;
    logic [2:0]         action;
    logic [1:0]         row_hit;
    logic [9:0]         bucket_hit;
    logic [31:0]        count_after;
    logic signed [31:0] hot_after;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    sketch_scoreboard   sb;
    int                 cycles;
    logic [63:0]        key_pool[16];

    heavy_hitter_sketch_update_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .flow_key     (flow_key),
        .random_value (random_value),
        .done         (done),
        .action       (action),
        .row_hit      (row_hit),
        .bucket_hit   (bucket_hit),
        .count_after  (count_after),
        .hot_after    (hot_after),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Collect updates
    always @(posedge clk)
    begin
        update_t got;
        if (rst_n && done)
        begin
            got.action = action;
            got.row    = row_hit;
            got.bucket = bucket_hit;
            got.count  = count_after;
            got.hot    = hot_after;
            sb.check_update(got);
        end
    end

    // Hold until busy falls and nothing is outstanding
    task automatic wait_idle();
        while (sb.pending_updates.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic configure(logic [31:0] width, logic [31:0] seed, logic [31:0] limit);
        wait_idle();
        write_reg(REG_ROW_WIDTH, width);
        write_reg(REG_HASH_SEED, seed);
        write_reg(REG_LOW_LIMIT, limit);
        for (int i = 0; i < 16; i++)
            key_pool[i] = ($urandom_range(0, 7) == 0) ? 64'd0 : {$urandom, $urandom};
    endtask

    // Present one item at the falling edge, hold until taken
    task automatic send_item(logic [63:0] key, logic [30:0] rnd, bit allow_gap);
        if (allow_gap && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk);
        start        = 1'b1;
        flow_key     = key;
        random_value = rnd;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_item(key, rnd);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic random_items(int n, bit allow_gap);
        logic [63:0] key;
        logic [30:0] rnd;
        for (int i = 0; i < n; i++)
        begin
            key = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                              : key_pool[$urandom_range(0, 15)];
            rnd = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 20));
            send_item(key, rnd, allow_gap);
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear_store();
        cycles       = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        flow_key     = '0;
        random_value = '0;
        cfg_write    = 1'b0;
        cfg_index    = REG_ROW_WIDTH;
        cfg_data     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: zero key on an empty bucket counts as a match
        send_item(64'd0, 31'd0, 0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 0);

        // One bucket per row: fill all rows, then exercise both decay outcomes
        configure(1, 0, 10);
        write_reg(REG_SPARE, $urandom);
        send_item(64'd0, 31'd0, 0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 0);
        send_item(64'd1, 31'd5, 0);
        send_item(64'd2, 31'd5, 0);
        send_item(64'd4, 31'd0, 0);
        send_item(64'd5, 31'h7FFF_FFFF, 0);
        for (int i = 0; i < 8; i++)
            send_item(64'd0, 31'd3, 0);
        send_item(64'd6, 31'd0, 0);
        send_item(64'd7, 31'h7FFF_FFFF, 0);
        // Count above the limit: product odds
        configure(1, 0, 0);
        send_item(64'd8, 31'd0, 0);
        send_item(64'd9, 31'h7FFF_FFFF, 0);
        send_item(64'd10, 31'd1, 0);

        // Random phases over several settings
        configure(1024, 0, 10);
        random_items(200, 1);
        configure(1, 32'hFFFF_FFFF, 0);
        random_items(200, 1);
        // Drain fully before sending more
        wait_idle();
        configure(0, $urandom, 65535);
        random_items(200, 1);
        configure(2047, $urandom, 3);
        random_items(200, 1);
        configure(3, $urandom, 10);
        random_items(300, 1);
        configure(8, $urandom, 0);
        random_items(300, 1);
        configure(2, $urandom, 1);
        random_items(250, 1);
        random_items(250, 0);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending_updates.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
